// ===== rtl/par_pkg.sv =====
`timescale 1ns / 1ps

package par_pkg;

  // Field widths of one item.
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned OP_W        = 2;

  // Number of CORDIC iterations, one pipeline stage each (8 to 32).
  localparam int unsigned CORDIC_STAGES = 20;

  // Internal datapath widths.
  localparam int unsigned ANG_EXT_W = ANGLE_W + 2;
  localparam int unsigned RAD_W     = 48;
  localparam int unsigned XY_W      = 34;
  localparam int unsigned Z_W       = 34;
  localparam int unsigned TRIG_W    = 32;
  localparam int unsigned TRIG_FRAC = 30;
  localparam int unsigned PROD_W    = COORD_WIDTH + TRIG_W;
  localparam int unsigned SUM_W     = PROD_W + 1;

  // Angle constants in 1/128 degree units.
  localparam logic signed [ANG_EXT_W-1:0] HALF_TURN    = ANG_EXT_W'(23040);
  localparam logic signed [ANG_EXT_W-1:0] QUARTER_TURN = ANG_EXT_W'(11520);
  localparam logic signed [ANG_EXT_W-1:0] FULL_TURN    = ANG_EXT_W'(46080);

  // 2^38 * pi / 23040, so that (angle * this + 128) >> 8 is radians in Q2.30.
  localparam logic signed [RAD_W-1:0] ANGLE_TO_RAD_Q8 = RAD_W'(37480660);
  localparam logic signed [RAD_W-1:0] RAD_ROUND       = RAD_W'(128);

  // Inverse CORDIC gain in Q2.30.
  localparam logic signed [XY_W-1:0] CORDIC_INV_GAIN = XY_W'(652032874);

  // round(atan(2^-i) * 2^30).
  localparam logic [29:0] ATAN_TABLE [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // Saturation bounds of one coordinate.
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Rotation axis codes; the fourth code passes the point through.
  typedef enum logic [OP_W-1:0] {
    OP_ROT_X = 2'd0,
    OP_ROT_Y = 2'd1,
    OP_ROT_Z = 2'd2
  } par_op_e;

  typedef struct packed {
    logic [OP_W-1:0]                operation;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [ANGLE_W-1:0]     angle_deg;
  } par_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
    logic                          saturated;
  } par_out_t;

  // Data that travels alongside the CORDIC pipeline.
  typedef struct packed {
    logic [OP_W-1:0]                operation;
    logic                          flip;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } par_side_t;

endpackage

// ===== rtl/par_if.sv =====
`timescale 1ns / 1ps

// Input channel: one point, angle and axis per item.
interface par_in_if;
  import par_pkg::*;

  logic    valid;
  logic    ready;
  par_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Output channel: one rotated point per item.
interface par_out_if;
  import par_pkg::*;

  logic     valid;
  logic     ready;
  par_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/par_cordic.sv =====
`timescale 1ns / 1ps

module par_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [par_pkg::Z_W-1:0]  z_i,
  input  par_pkg::par_side_t              side_i,
  output logic                            valid_o,
  output logic signed [par_pkg::XY_W-1:0] cos_o,
  output logic signed [par_pkg::XY_W-1:0] sin_o,
  output par_pkg::par_side_t              side_o
);
  import par_pkg::*;

  logic signed [XY_W-1:0] x_q    [CORDIC_STAGES];
  logic signed [XY_W-1:0] y_q    [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_q    [CORDIC_STAGES];
  logic                   v_q    [CORDIC_STAGES];
  par_side_t              side_q [CORDIC_STAGES];

  // One micro-rotation per stage; the whole pipeline moves when en_i is high.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] x_in, y_in, x_d, y_d;
    logic signed [Z_W-1:0]  z_in, z_d;
    logic                   v_in;
    par_side_t              s_in;

    if (i == 0) begin : g_first
      assign x_in = CORDIC_INV_GAIN;
      assign y_in = '0;
      assign z_in = z_i;
      assign v_in = valid_i;
      assign s_in = side_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign v_in = v_q[i-1];
      assign s_in = side_q[i-1];
    end

    // Rotate towards zero residual angle.
    always_comb begin
      if (z_in >= 0) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - Z_W'(ATAN_TABLE[i]);
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + Z_W'(ATAN_TABLE[i]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_d;
        y_q[i]    <= y_d;
        z_q[i]    <= z_d;
        side_q[i] <= s_in;
      end
    end
  end

  assign valid_o = v_q[CORDIC_STAGES-1];
  assign cos_o   = x_q[CORDIC_STAGES-1];
  assign sin_o   = y_q[CORDIC_STAGES-1];
  assign side_o  = side_q[CORDIC_STAGES-1];

endmodule

// ===== rtl/point_axis_rotation.sv =====
`timescale 1ns / 1ps

// Rotates a 3D point (signed Q16.16) about the x, y or z axis.
// in_i carries one item per point: axis code, the three coordinates and an
// angle in 1/128 degree. out_o returns one item per input item, in order:
// the rotated point, each coordinate rounded and saturated, with a flag set
// when any coordinate was clamped. The axis code 3 passes the point through.
// From an accepted input item to its result showing valid, the item passes
// through the input register, the angle conversion, one pipeline stage per
// CORDIC iteration, the multiply stage, the add and saturate stage, and the
// output register. Throughput is one item per cycle while the receiver
// takes results, set by the fully pipelined CORDIC.
// When the receiver stalls, the result waiting in the output register holds
// and one more item is caught in a skid register; only then does in_i.ready
// fall, and the whole pipeline holds until the output is taken.
// Reset clears all valid flags; no clearing pass is needed, and in_i.ready
// is high directly after reset.
module point_axis_rotation (
  input  logic        clk_i,
  input  logic        rst_ni,
  par_in_if.sink      in_i,
  par_out_if.source   out_o
);
  import par_pkg::*;

  logic en;

  logic      s0_valid_q;
  par_in_t   s0_data_q;

  logic signed [ANG_EXT_W-1:0] ang_w, ang_a, ang_f;
  logic                        flip;
  logic signed [RAD_W-1:0]     zrad;
  logic signed [Z_W-1:0]       z_pre;
  par_side_t                   side_pre;

  logic                  s1_valid_q;
  logic signed [Z_W-1:0] s1_z_q;
  par_side_t             s1_side_q;

  logic                   c_valid;
  logic signed [XY_W-1:0] c_x, c_y, cx_f, cy_f;
  par_side_t              c_side;

  logic signed [COORD_WIDTH-1:0] a_sel, b_sel;
  logic signed [TRIG_W-1:0]      cos_t, sin_t;
  logic signed [PROD_W-1:0]      p_ac_d, p_bs_d, p_as_d, p_bc_d;
  logic signed [PROD_W-1:0]      p_ac_q, p_bs_q, p_as_q, p_bc_q;
  logic                          m_valid_q;
  par_side_t                     m_side_q;

  logic signed [SUM_W-1:0] sum_a, sum_b, rnd_a, rnd_b;
  logic [COORD_WIDTH:0]    cl_a, cl_b;
  par_out_t                res;

  logic     t_valid_q;
  par_out_t t_data_q;

  logic     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  par_out_t out_data_q, out_data_d, skid_data_q, skid_data_d;

  localparam logic signed [SUM_W-1:0] ROUND_HALF  = SUM_W'(1) << (TRIG_FRAC - 1);
  localparam logic signed [SUM_W-1:0] COORD_MAX_S = SUM_W'(COORD_MAX);
  localparam logic signed [SUM_W-1:0] COORD_MIN_S = ~COORD_MAX_S;

  // Clamp a rounded sum to the coordinate range; the top bit flags a clamp.
  function automatic logic [COORD_WIDTH:0] clamp_coord(logic signed [SUM_W-1:0] v);
    if (v > COORD_MAX_S) begin
      return {1'b1, COORD_MAX};
    end else if (v < COORD_MIN_S) begin
      return {1'b1, COORD_MIN};
    end
    return {1'b0, v[COORD_WIDTH-1:0]};
  endfunction

  // The pipeline moves whenever the skid register is free.
  assign en         = !skid_valid_q;
  assign in_i.ready = en;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_data_q <= in_i.data;
    end
  end

  // Wrap the angle into half a turn, fold it into a quarter turn and
  // convert it to radians in Q2.30.
  always_comb begin
    ang_w = ANG_EXT_W'(s0_data_q.angle_deg);
    ang_a = ang_w;
    if (ang_w > HALF_TURN) begin
      ang_a = ang_w - FULL_TURN;
    end else if (ang_w < -HALF_TURN) begin
      ang_a = ang_w + FULL_TURN;
    end
    flip  = 1'b0;
    ang_f = ang_a;
    if (ang_a > QUARTER_TURN) begin
      ang_f = ang_a - HALF_TURN;
      flip  = 1'b1;
    end else if (ang_a < -QUARTER_TURN) begin
      ang_f = ang_a + HALF_TURN;
      flip  = 1'b1;
    end
    zrad  = RAD_W'(ang_f) * ANGLE_TO_RAD_Q8 + RAD_ROUND;
    z_pre = zrad[Z_W+7:8];

    side_pre.operation = s0_data_q.operation;
    side_pre.flip      = flip;
    side_pre.point_x   = s0_data_q.point_x;
    side_pre.point_y   = s0_data_q.point_y;
    side_pre.point_z   = s0_data_q.point_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_z_q    <= z_pre;
      s1_side_q <= side_pre;
    end
  end

  par_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .z_i     (s1_z_q),
    .side_i  (s1_side_q),
    .valid_o (c_valid),
    .cos_o   (c_x),
    .sin_o   (c_y),
    .side_o  (c_side)
  );

  // Undo the fold, pick the two coordinates in the rotation plane and
  // form the four products.
  always_comb begin
    cx_f  = c_side.flip ? -c_x : c_x;
    cy_f  = c_side.flip ? -c_y : c_y;
    cos_t = cx_f[TRIG_W-1:0];
    sin_t = cy_f[TRIG_W-1:0];
    case (par_op_e'(c_side.operation))
      OP_ROT_Y: begin
        a_sel = c_side.point_z;
        b_sel = c_side.point_x;
      end
      OP_ROT_Z: begin
        a_sel = c_side.point_x;
        b_sel = c_side.point_y;
      end
      default: begin
        a_sel = c_side.point_y;
        b_sel = c_side.point_z;
      end
    endcase
    p_ac_d = a_sel * cos_t;
    p_bs_d = b_sel * sin_t;
    p_as_d = a_sel * sin_t;
    p_bc_d = b_sel * cos_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ac_q   <= p_ac_d;
      p_bs_q   <= p_bs_d;
      p_as_q   <= p_as_d;
      p_bc_q   <= p_bc_d;
      m_side_q <= c_side;
    end
  end

  // Sum, round to nearest with ties upward, saturate and place the results.
  always_comb begin
    sum_a = SUM_W'(p_ac_q) - SUM_W'(p_bs_q);
    sum_b = SUM_W'(p_as_q) + SUM_W'(p_bc_q);
    rnd_a = (sum_a + ROUND_HALF) >>> TRIG_FRAC;
    rnd_b = (sum_b + ROUND_HALF) >>> TRIG_FRAC;
    cl_a  = clamp_coord(rnd_a);
    cl_b  = clamp_coord(rnd_b);

    res.rot_x     = m_side_q.point_x;
    res.rot_y     = m_side_q.point_y;
    res.rot_z     = m_side_q.point_z;
    res.saturated = cl_a[COORD_WIDTH] | cl_b[COORD_WIDTH];
    case (par_op_e'(m_side_q.operation))
      OP_ROT_X: begin
        res.rot_y = cl_a[COORD_WIDTH-1:0];
        res.rot_z = cl_b[COORD_WIDTH-1:0];
      end
      OP_ROT_Y: begin
        res.rot_z = cl_a[COORD_WIDTH-1:0];
        res.rot_x = cl_b[COORD_WIDTH-1:0];
      end
      OP_ROT_Z: begin
        res.rot_x = cl_a[COORD_WIDTH-1:0];
        res.rot_y = cl_b[COORD_WIDTH-1:0];
      end
      default: begin
        res.saturated = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
    end else if (en) begin
      t_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_data_q <= res;
    end
  end

  // Output register with a skid register behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = t_valid_q;
        out_data_d  = t_data_q;
      end
    end else if (t_valid_q && !skid_valid_q) begin
      skid_valid_d = 1'b1;
      skid_data_d  = t_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== rtl/par_checker.sv =====
`timescale 1ns / 1ps

module par_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input par_pkg::par_out_t   out_data_i
);
  import par_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  // Input back-pressure only ever comes with a result waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input not ready while no result is pending");

  // The input side stops only after the output was stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(out_valid_i && !out_ready_i))
    else $error("input ready fell without an output stall");

  // A clamp flag means at least one coordinate sits on a bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.saturated |->
      (out_data_i.rot_x == COORD_MAX) || (out_data_i.rot_x == COORD_MIN) ||
      (out_data_i.rot_y == COORD_MAX) || (out_data_i.rot_y == COORD_MIN) ||
      (out_data_i.rot_z == COORD_MAX) || (out_data_i.rot_z == COORD_MIN))
    else $error("saturated flag set with no coordinate on a bound");

endmodule

bind point_axis_rotation par_checker u_par_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ===== verif/tb_point_axis_rotation.sv =====
`timescale 1ns / 1ps

module tb_point_axis_rotation;
  import par_pkg::*;

  // Axis code outside the enum: the point passes through unchanged.
  localparam logic [OP_W-1:0] OP_PASS = 2'd3;

  localparam int unsigned LATENCY     = CORDIC_STAGES + 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 312;

  localparam logic [COORD_WIDTH-1:0] Q_ONE = 32'h0001_0000;

  // Arctangent of 2^-i in Q2.30 for each CORDIC iteration.
  localparam longint ATAN_Q30 [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0
  };

  // Holds the rotated points still to come back and checks each result.
  class rotation_scoreboard;
    par_out_t    rotated_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Cosine and sine in Q2.30 of an angle in 1/128 degree.
    function void cordic_cos_sin(input longint ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      logic   flip;
      flip = 1'b0;
      if (ang > 23040) ang -= 46080;
      if (ang < -23040) ang += 46080;
      // Fold into a quarter turn either side; this negates both results.
      if (ang > 11520) begin
        ang -= 23040;
        flip = 1'b1;
      end
      if (ang < -11520) begin
        ang += 23040;
        flip = 1'b1;
      end
      z = (ang * longint'(37480660) + 128) >>> 8;
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= ATAN_Q30[i];
        end else begin
          x += dx;
          y -= dy;
          z += ATAN_Q30[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // Rounded sum of two Q2.30 products, ties upward.
    function longint mix(longint a, longint b, longint c1, longint c2);
      return (a * c1 + b * c2 + (longint'(1) << 29)) >>> 30;
    endfunction

    function par_out_t rotate_point(par_in_t item);
      longint coord[3];
      longint c, s, va, vb;
      int     ia, ib;
      logic   sat;
      par_out_t res;
      coord[0] = longint'($signed(item.point_x));
      coord[1] = longint'($signed(item.point_y));
      coord[2] = longint'($signed(item.point_z));
      sat = 1'b0;
      if (item.operation != OP_PASS) begin
        case (item.operation)
          OP_ROT_X: begin
            ia = 1;
            ib = 2;
          end
          OP_ROT_Y: begin
            ia = 2;
            ib = 0;
          end
          default: begin
            ia = 0;
            ib = 1;
          end
        endcase
        cordic_cos_sin(longint'($signed(item.angle_deg)), c, s);
        va = mix(coord[ia], coord[ib], c, -s);
        vb = mix(coord[ia], coord[ib], s, c);
        coord[ia] = va;
        coord[ib] = vb;
        // Clamp each rotated coordinate to the signed 32-bit range.
        foreach (coord[k]) begin
          if (coord[k] > 64'sd2147483647) begin
            coord[k] = 64'sd2147483647;
            sat = 1'b1;
          end else if (coord[k] < -64'sd2147483648) begin
            coord[k] = -64'sd2147483648;
            sat = 1'b1;
          end
        end
      end
      res.rot_x     = coord[0][COORD_WIDTH-1:0];
      res.rot_y     = coord[1][COORD_WIDTH-1:0];
      res.rot_z     = coord[2][COORD_WIDTH-1:0];
      res.saturated = sat;
      return res;
    endfunction

    function void note_point(par_in_t item);
      rotated_q.push_back(rotate_point(item));
    endfunction

    function void check_point(par_out_t got);
      par_out_t want;
      if (rotated_q.size() == 0) begin
        $error("result item with no rotated point pending");
        mismatches++;
        return;
      end
      want = rotated_q.pop_front();
      if (got.rot_x !== want.rot_x) begin
        $error("rot_x: expected %0d, got %0d", want.rot_x, got.rot_x);
        mismatches++;
      end
      if (got.rot_y !== want.rot_y) begin
        $error("rot_y: expected %0d, got %0d", want.rot_y, got.rot_y);
        mismatches++;
      end
      if (got.rot_z !== want.rot_z) begin
        $error("rot_z: expected %0d, got %0d", want.rot_z, got.rot_z);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  par_in_if  in_ch ();
  par_out_if out_ch ();

  point_axis_rotation dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  rotation_scoreboard sb = new();

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check each accepted item, then choose the next ready, with
  // long hold-offs counted down here.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        sb.check_point(out_ch.data);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offers one item, with random idle cycles first, and notes it once taken.
  task automatic send_point(input par_in_t item);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_point(item);
  endtask

  task automatic send_case(input logic [OP_W-1:0] op, input logic [COORD_WIDTH-1:0] x,
                           input logic [COORD_WIDTH-1:0] y,
                           input logic [COORD_WIDTH-1:0] z,
                           input logic [ANGLE_W-1:0] ang);
    par_in_t item;
    item.operation = op;
    item.point_x   = x;
    item.point_y   = y;
    item.point_z   = z;
    item.angle_deg = ang;
    send_point(item);
  endtask

  // Coordinates are mostly full range or modest, some near either bound.
  function automatic logic [COORD_WIDTH-1:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom();
    if (pick < 8) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    if (pick == 8) return 32'h7fff_ffff - $urandom_range(0, 32'h0001_0000);
    return 32'h8000_0000 + $urandom_range(0, 32'h0001_0000);
  endfunction

  function automatic par_in_t random_point();
    par_in_t item;
    if ($urandom_range(0, 9) == 0) item.operation = OP_PASS;
    else item.operation = OP_W'($urandom_range(0, 2));
    item.point_x = random_coord();
    item.point_y = random_coord();
    item.point_z = random_coord();
    // Mostly within half a turn; the rest over the whole 16-bit range.
    if ($urandom_range(0, 4) != 0)
      item.angle_deg = ANGLE_W'($urandom_range(0, 46080) - 23040);
    else item.angle_deg = ANGLE_W'($urandom());
    return item;
  endfunction

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each axis, quarter and half turns, wrap and fold, extremes.
    send_case(OP_ROT_X, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 16'sd0);
    send_case(OP_ROT_Y, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 16'sd11520);
    send_case(OP_ROT_Z, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, -16'sd11520);
    send_case(OP_ROT_X, Q_ONE, -Q_ONE, 5 * Q_ONE, 16'sd23040);
    send_case(OP_ROT_Y, -Q_ONE, Q_ONE, 7 * Q_ONE, -16'sd23040);
    send_case(OP_ROT_Z, 3 * Q_ONE, Q_ONE, 0, 16'sd23041);
    send_case(OP_ROT_X, 0, 4 * Q_ONE, -Q_ONE, -16'sd32768);
    send_case(OP_ROT_Y, Q_ONE, 0, 9 * Q_ONE, 16'sd32767);
    send_case(OP_ROT_Z, 5 * Q_ONE, -2 * Q_ONE, 0, 16'sd11521);
    send_case(OP_ROT_X, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'sd5760);
    send_case(OP_ROT_Y, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'sd5760);
    send_case(OP_ROT_Z, 32'h8000_0000, 32'h8000_0000, 0, 16'sd23040);
    send_case(OP_ROT_Z, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, -16'sd5760);
    send_case(OP_ROT_X, 0, 32'h7fff_ffff, 32'h8000_0000, 16'sd17280);
    send_case(OP_PASS, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'sd5760);
    send_case(OP_PASS, 32'h1234_5678, 32'h8765_4321, 0, -16'sd32768);
    send_case(OP_ROT_X, 0, 0, 0, 16'sd1);
    send_case(OP_ROT_Y, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, -16'sd1);
    send_case(OP_ROT_Z, Q_ONE, Q_ONE, Q_ONE, 16'sd7680);
    send_case(OP_ROT_Y, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 16'h5555);

    // Random: no idling, sender gaps, receiver stalls, then both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 47;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 47;
        end
        default: begin
          gap_pct   = 13;
          stall_pct = 13;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // A long hold-off on the result side while items keep coming, so
        // the pipeline fills and the input stalls.
        if (phase == 0 && n == 100) hold_left = 300;
        send_point(random_point());
      end
    end

    // Drain the pipeline and allow for any stray result.
    in_ch.valid <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    while (sb.rotated_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== point_axis_rotation.f =====
rtl/par_pkg.sv
rtl/par_if.sv
rtl/par_cordic.sv
rtl/point_axis_rotation.sv
rtl/par_checker.sv
verif/tb_point_axis_rotation.sv
